// ----- design/acs_pkg.sv -----
// shared types, constants and codes for the box culling scan block
`timescale 1ns / 1ps
package acs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PAD_W       = 31;
  localparam int OUT_IDX_W   = 6;
  // wide enough for a coordinate minus or plus the pad
  localparam int EXT_W       = ((COORD_WIDTH > PAD_W) ? COORD_WIDTH : PAD_W) + 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2
  } acs_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } acs_state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               is_local;
    logic               is_unbounded;
  } acs_req_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 found;
    logic                 last;
  } acs_rsp_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] min_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;
  } acs_box_t;

  typedef struct packed {
    logic     is_local;
    logic     is_unbounded;
    acs_box_t box;
  } acs_entry_t;

endpackage

// ----- design/acs_box_ram.sv -----
// generic single-port-write, single-port-read synchronous ram, registered read
`timescale 1ns / 1ps
module acs_box_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/acs_region.sv -----
// query region register with saturating pad widening
`timescale 1ns / 1ps
module acs_region import acs_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  acs_req_t         req_i,
  input  logic [PAD_W-1:0] pad_i,
  output acs_box_t         region_o,
  output logic             unbounded_o
);

  localparam logic signed [EXT_W-1:0] C_HI =
    $signed((EXT_W'(1) << (COORD_WIDTH - 1)) - EXT_W'(1));
  localparam logic signed [EXT_W-1:0] C_LO = -C_HI - EXT_W'(1);

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [EXT_W-1:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    if (v > C_HI) begin
      r = C_HI[COORD_WIDTH-1:0];
    end else if (v < C_LO) begin
      r = C_LO[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [EXT_W-1:0] ext(input logic signed [31:0] c);
    logic signed [COORD_WIDTH-1:0] t;
    t = c[COORD_WIDTH-1:0];
    return EXT_W'(t);
  endfunction

  logic signed [EXT_W-1:0] pad_ext;
  acs_box_t                region_d, region_q;
  logic                    unb_q;

  assign pad_ext = $signed(EXT_W'(pad_i));

  always_comb begin
    region_d.min_x = sat(ext(req_i.min_x) - pad_ext);
    region_d.min_y = sat(ext(req_i.min_y) - pad_ext);
    region_d.min_z = sat(ext(req_i.min_z) - pad_ext);
    region_d.max_x = sat(ext(req_i.max_x) + pad_ext);
    region_d.max_y = sat(ext(req_i.max_y) + pad_ext);
    region_d.max_z = sat(ext(req_i.max_z) + pad_ext);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      region_q <= region_d;
      unb_q    <= req_i.is_unbounded;
    end
  end

  assign region_o    = region_q;
  assign unbounded_o = unb_q;

endmodule

// ----- design/acs_overlap.sv -----
// survival test of one stored entry against the query region
`timescale 1ns / 1ps
module acs_overlap import acs_pkg::*; (
  input  acs_entry_t entry_i,
  input  acs_box_t   region_i,
  input  logic       region_unb_i,
  output logic       keep_o
);

  logic non_empty;
  logic overlap;

  assign non_empty = (entry_i.box.min_x <= entry_i.box.max_x) &&
                     (entry_i.box.min_y <= entry_i.box.max_y) &&
                     (entry_i.box.min_z <= entry_i.box.max_z);

  assign overlap = (entry_i.box.min_x <= region_i.max_x) &&
                   (entry_i.box.max_x >= region_i.min_x) &&
                   (entry_i.box.min_y <= region_i.max_y) &&
                   (entry_i.box.max_y >= region_i.min_y) &&
                   (entry_i.box.min_z <= region_i.max_z) &&
                   (entry_i.box.max_z >= region_i.min_z);

  always_comb begin
    if (!entry_i.is_local || entry_i.is_unbounded) begin
      keep_o = 1'b1;
    end else if (region_unb_i) begin
      keep_o = non_empty;
    end else begin
      keep_o = overlap;
    end
  end

endmodule

// ----- design/aabb_cull_scan_core.sv -----
// top level: entry table, scan sequencer and result register of the box culling scan
// throughput: a query holds the input until its final result is registered, reading one entry
//   ram word per cycle while the output does not stall; loads and clears one per cycle
// reset: entry count and pad clear at once, table contents stay undefined until loaded
`timescale 1ns / 1ps
module aabb_cull_scan_core import acs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  acs_req_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output acs_rsp_t         out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [PAD_W-1:0] cfg_wdata_i
);

  acs_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             s1_vld_q, s1_vld_d;
  logic [IDX_W-1:0] s1_idx_q, s1_idx_d;
  logic             pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             out_vld_q, out_vld_d;
  acs_rsp_t         out_q, out_d;
  logic             out_we;
  logic [PAD_W-1:0] pad_q, pad_d;

  logic       in_fire;
  logic       ram_we, ram_re;
  acs_entry_t wr_entry, rd_entry;
  logic [$bits(acs_entry_t)-1:0] rd_data;
  acs_box_t   region;
  logic       region_unb;
  logic       region_load;
  logic       keep;
  logic       move, s1_fire, done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    wr_entry.is_local     = in_req_i.is_local;
    wr_entry.is_unbounded = in_req_i.is_unbounded;
    wr_entry.box.min_x    = in_req_i.min_x[COORD_WIDTH-1:0];
    wr_entry.box.min_y    = in_req_i.min_y[COORD_WIDTH-1:0];
    wr_entry.box.min_z    = in_req_i.min_z[COORD_WIDTH-1:0];
    wr_entry.box.max_x    = in_req_i.max_x[COORD_WIDTH-1:0];
    wr_entry.box.max_y    = in_req_i.max_y[COORD_WIDTH-1:0];
    wr_entry.box.max_z    = in_req_i.max_z[COORD_WIDTH-1:0];
  end

  acs_box_ram #(
    .WIDTH ($bits(acs_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_entry = acs_entry_t'(rd_data);

  acs_region u_region (
    .clk_i       (clk_i),
    .load_i      (region_load),
    .req_i       (in_req_i),
    .pad_i       (pad_q),
    .region_o    (region),
    .unbounded_o (region_unb)
  );

  acs_overlap u_overlap (
    .entry_i      (rd_entry),
    .region_i     (region),
    .region_unb_i (region_unb),
    .keep_o       (keep)
  );

  // the last survivor is held back until the scan ends so it can carry last
  assign move    = !out_vld_q || out_ready_i;
  assign s1_fire = s1_vld_q && (move || !pend_vld_q || !keep);
  assign done    = (state_q == ST_SCAN) && (rd_ptr_q == count_q) && !s1_vld_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    out_we      = 1'b0;
    pad_d       = cfg_we_i ? cfg_wdata_i : pad_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    region_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_i.op)
            OP_LOAD: begin
              if (count_q < CNT_W'(TABLE_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_QUERY: begin
              region_load = 1'b1;
              rd_ptr_d    = '0;
              pend_vld_d  = 1'b0;
              state_d     = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (s1_fire) begin
          s1_vld_d = 1'b0;
          if (keep) begin
            pend_vld_d = 1'b1;
            pend_idx_d = s1_idx_q;
            if (pend_vld_q) begin
              out_we            = 1'b1;
              out_d.entry_index = OUT_IDX_W'(pend_idx_q);
              out_d.found       = 1'b1;
              out_d.last        = 1'b0;
            end
          end
        end
        if ((rd_ptr_q < count_q) && (!s1_vld_q || s1_fire)) begin
          ram_re   = 1'b1;
          s1_vld_d = 1'b1;
          s1_idx_d = rd_ptr_q[IDX_W-1:0];
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end
        if (done && move) begin
          out_we            = 1'b1;
          out_d.entry_index = pend_vld_q ? OUT_IDX_W'(pend_idx_q) : '0;
          out_d.found       = pend_vld_q;
          out_d.last        = 1'b1;
          pend_vld_d        = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_we) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rd_ptr_q   <= '0;
      s1_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      pad_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_ptr_q   <= rd_ptr_d;
      s1_vld_q   <= s1_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      pad_q      <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= s1_idx_d;
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // scan pipeline is only busy during a query
  a_s1_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q || pend_vld_q) |-> (state_q == ST_SCAN))
    else $error("scan pipeline busy outside a query");

  // reads never go past the loaded entries
  a_read_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (rd_ptr_q < count_q))
    else $error("entry read beyond fill count");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // a no-survivor result always closes the query at index zero
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.found) |-> (out_q.last && (out_q.entry_index == '0)))
    else $error("empty result not final");

  // the query ends with a result registered as it returns to idle
  a_done_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_IDLE) |=> (out_vld_q && out_q.last))
    else $error("query ended without final result");

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the box culling scan block
`timescale 1ns / 1ps
module tb import acs_pkg::*;;

  localparam int          CLK_HALF      = 2;
  localparam int          RESET_CYCLES  = 10;
  localparam int          SETTLE_CYCLES = 8;
  localparam longint      LIMIT_CYCLES  = 1000000;
  localparam int          ONE           = 65536;
  localparam int          CRD_MAX       = 2147483647;
  localparam int          CRD_MIN       = -2147483647 - 1;
  localparam logic [PAD_W-1:0] PAD_MAX  = '1;
  // op code the block has no use for
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  acs_req_t         in_req_i;
  logic             out_valid_o;
  logic             out_ready_i;
  acs_rsp_t         out_rsp_o;
  logic             cfg_we_i;
  logic [PAD_W-1:0] cfg_wdata_i;

  aabb_cull_scan_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow of the block state
  acs_entry_t       shadow_table [TABLE_DEPTH];
  int               shadow_count;
  logic [PAD_W-1:0] shadow_pad;

  acs_rsp_t expected_hits_q [$];
  acs_rsp_t want_rsp;

  int     fail_cnt;
  int     items_sent;
  int     loads_sent;
  int     clears_sent;
  int     queries_sent;
  int     results_checked;
  int     misses_seen;
  int     send_idle_pct;
  int     rcv_idle_pct;
  longint cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hits_q.size() == 0) begin
        $error("unexpected result: entry_index %0d found %0b last %0b",
               out_rsp_o.entry_index, out_rsp_o.found, out_rsp_o.last);
        fail_cnt++;
      end else begin
        want_rsp = expected_hits_q.pop_front();
        results_checked++;
        if (out_rsp_o.entry_index !== want_rsp.entry_index) begin
          $error("entry_index: expected %0d, actual %0d",
                 want_rsp.entry_index, out_rsp_o.entry_index);
          fail_cnt++;
        end
        if (out_rsp_o.found !== want_rsp.found) begin
          $error("found: expected %0b, actual %0b", want_rsp.found, out_rsp_o.found);
          fail_cnt++;
        end
        if (out_rsp_o.last !== want_rsp.last) begin
          $error("last: expected %0b, actual %0b", want_rsp.last, out_rsp_o.last);
          fail_cnt++;
        end
      end
    end
  end

  // works out the surviving slots of a query, or updates the shadow table
  function automatic void predict_survivors(input acs_req_t req);
    longint   rgn_lo [3];
    longint   rgn_hi [3];
    longint   ent_lo [3];
    longint   ent_hi [3];
    longint   lim_hi;
    longint   lim_lo;
    acs_entry_t ent;
    acs_rsp_t rsp;
    bit       keep;
    int       hits;
    lim_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lim_lo = -lim_hi - 1;
    hits   = 0;
    case (req.op)
      OP_LOAD: begin
        if (shadow_count < TABLE_DEPTH) begin
          ent.is_local     = req.is_local;
          ent.is_unbounded = req.is_unbounded;
          ent.box.min_x    = req.min_x;
          ent.box.min_y    = req.min_y;
          ent.box.min_z    = req.min_z;
          ent.box.max_x    = req.max_x;
          ent.box.max_y    = req.max_y;
          ent.box.max_z    = req.max_z;
          shadow_table[shadow_count] = ent;
          shadow_count++;
        end
      end
      OP_CLEAR: shadow_count = 0;
      OP_QUERY: begin
        rgn_lo = '{longint'(req.min_x), longint'(req.min_y), longint'(req.min_z)};
        rgn_hi = '{longint'(req.max_x), longint'(req.max_y), longint'(req.max_z)};
        if (shadow_pad != 0) begin
          for (int a = 0; a < 3; a++) begin
            rgn_lo[a] = rgn_lo[a] - longint'(shadow_pad);
            rgn_hi[a] = rgn_hi[a] + longint'(shadow_pad);
            if (rgn_lo[a] < lim_lo) rgn_lo[a] = lim_lo;
            if (rgn_hi[a] > lim_hi) rgn_hi[a] = lim_hi;
          end
        end
        for (int i = 0; i < shadow_count; i++) begin
          ent = shadow_table[i];
          ent_lo = '{longint'($signed(ent.box.min_x)), longint'($signed(ent.box.min_y)),
                     longint'($signed(ent.box.min_z))};
          ent_hi = '{longint'($signed(ent.box.max_x)), longint'($signed(ent.box.max_y)),
                     longint'($signed(ent.box.max_z))};
          keep = 1'b1;
          if (ent.is_local && !ent.is_unbounded) begin
            for (int a = 0; a < 3; a++) begin
              if (req.is_unbounded) begin
                // infinite region: only an empty entry box is culled
                if (ent_lo[a] > ent_hi[a]) keep = 1'b0;
              end else if (!(ent_lo[a] <= rgn_hi[a] && ent_hi[a] >= rgn_lo[a])) begin
                keep = 1'b0;
              end
            end
          end
          if (keep) begin
            rsp.entry_index = i[OUT_IDX_W-1:0];
            rsp.found       = 1'b1;
            rsp.last        = 1'b0;
            expected_hits_q.insert(expected_hits_q.size(), rsp);
            hits++;
          end
        end
        if (hits == 0) begin
          rsp.entry_index = '0;
          rsp.found       = 1'b0;
          rsp.last        = 1'b1;
          expected_hits_q.insert(expected_hits_q.size(), rsp);
          misses_seen++;
        end else begin
          expected_hits_q[expected_hits_q.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // enters at or before a falling edge, returns at the accepting rising edge
  task automatic send_req(input acs_req_t req);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    do @(posedge clk_i); while (!in_ready_o);
    predict_survivors(req);
    case (req.op)
      OP_LOAD:  loads_sent++;
      OP_CLEAR: clears_sent++;
      OP_QUERY: queries_sent++;
      default: ;
    endcase
    if (req.op != OP_UNUSED) items_sent++;
  endtask

  // hold off requests until every expected result is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_hits_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_pad(input logic [PAD_W-1:0] val);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    shadow_pad  = val;
  endtask

  function automatic acs_req_t mk_req(input logic [1:0] op, input int lx, input int ly,
                                      input int lz, input int hx, input int hy,
                                      input int hz, input bit loc, input bit unb);
    acs_req_t r;
    r = '{op: op, min_x: lx, min_y: ly, min_z: lz, max_x: hx, max_y: hy, max_z: hz,
          is_local: loc, is_unbounded: unb};
    return r;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? CRD_MAX : CRD_MIN;
      default: return (int'($urandom_range(0, 256)) - 128) * ONE + int'($urandom_range(0, ONE - 1));
    endcase
  endfunction

  function automatic void rand_span(output int lo, output int hi);
    int t;
    lo = rand_coord();
    if ($urandom_range(0, 4) == 0) hi = rand_coord();
    else hi = lo + int'($urandom_range(0, 48 * ONE));
    // some empty spans on purpose
    if ($urandom_range(0, 9) == 0) begin
      t = lo; lo = hi; hi = t;
    end
  endfunction

  function automatic acs_req_t rand_req(input logic [1:0] op);
    acs_req_t r;
    int lo, hi;
    r.op = op;
    rand_span(lo, hi); r.min_x = lo; r.max_x = hi;
    rand_span(lo, hi); r.min_y = lo; r.max_y = hi;
    rand_span(lo, hi); r.min_z = lo; r.max_z = hi;
    r.is_local     = ($urandom_range(0, 3) != 0);
    r.is_unbounded = ($urandom_range(0, 6) == 0);
    return r;
  endfunction

  // clears and unused ops carry junk in every field but the op code
  function automatic acs_req_t junk_req(input logic [1:0] op);
    acs_req_t r;
    r = '{op: op, min_x: $urandom, min_y: $urandom, min_z: $urandom, max_x: $urandom,
          max_y: $urandom, max_z: $urandom, is_local: 1'($urandom_range(0, 1)),
          is_unbounded: 1'($urandom_range(0, 1))};
    return r;
  endfunction

  function automatic logic [PAD_W-1:0] pick_pad();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return PAD_MAX;
      2:       return PAD_W'($urandom);
      default: return PAD_W'($urandom_range(1, 8 * ONE));
    endcase
  endfunction

  task automatic test_empty_table();
    write_pad('0);
    send_req(mk_req(OP_QUERY, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0, 1'b0));
    send_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
  endtask

  task automatic test_cull_rules();
    // non-local with an empty box, then unbounded with an empty box
    send_req(mk_req(OP_LOAD, 9 * ONE, 9 * ONE, 9 * ONE, -9 * ONE, -9 * ONE, -9 * ONE,
                    1'b0, 1'b0));
    send_req(mk_req(OP_LOAD, 5 * ONE, 0, 0, -5 * ONE, 0, 0, 1'b1, 1'b1));
    send_req(mk_req(OP_LOAD, 0, 0, 0, 10 * ONE, 10 * ONE, 10 * ONE, 1'b1, 1'b0));
    send_req(mk_req(OP_LOAD, 5 * ONE, 0, 0, -5 * ONE, 10 * ONE, 10 * ONE, 1'b1, 1'b0));
    send_req(mk_req(OP_LOAD, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                    1'b1, 1'b0));
    send_req(mk_req(OP_LOAD, 100 * ONE, 100 * ONE, 100 * ONE, 200 * ONE, 200 * ONE,
                    200 * ONE, 1'b1, 1'b0));
    // region touching slot 2 exactly on its upper face
    send_req(mk_req(OP_QUERY, 10 * ONE, 10 * ONE, 10 * ONE, 20 * ONE, 20 * ONE, 20 * ONE,
                    1'b0, 1'b0));
    send_req(mk_req(OP_QUERY, 10 * ONE + 1, 0, 0, 20 * ONE, 20 * ONE, 20 * ONE, 1'b0, 1'b0));
    send_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    // inverted region is not treated as empty
    send_req(mk_req(OP_QUERY, 150 * ONE, 150 * ONE, 150 * ONE, 5 * ONE, 5 * ONE, 5 * ONE,
                    1'b0, 1'b0));
    send_req(junk_req(OP_UNUSED));
    send_req(mk_req(OP_QUERY, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                    1'b0, 1'b0));
  endtask

  task automatic test_pad_widening();
    write_pad(ONE);
    send_req(mk_req(OP_QUERY, 11 * ONE, 0, 0, 20 * ONE, 20 * ONE, 20 * ONE, 1'b0, 1'b0));
    send_req(mk_req(OP_QUERY, 201 * ONE, 201 * ONE, 201 * ONE, 300 * ONE, 300 * ONE,
                    300 * ONE, 1'b0, 1'b0));
    // widest pad; the full-range query saturates at both ends
    write_pad(PAD_MAX);
    send_req(mk_req(OP_QUERY, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN,
                    1'b0, 1'b0));
    send_req(mk_req(OP_QUERY, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                    1'b0, 1'b0));
    write_pad('0);
  endtask

  task automatic test_clear();
    send_req(junk_req(OP_CLEAR));
    send_req(mk_req(OP_QUERY, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                    1'b0, 1'b1));
    send_req(junk_req(OP_CLEAR));
  endtask

  task automatic test_full_table();
    send_req(junk_req(OP_CLEAR));
    // two loads past the end must be dropped
    repeat (TABLE_DEPTH + 2) send_req(rand_req(OP_LOAD));
    send_req(rand_req(OP_QUERY));
    send_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic run_traffic(input int n_items);
    int start;
    int seq_no;
    start  = items_sent;
    seq_no = 0;
    while (items_sent - start < n_items) begin
      if (seq_no % 4 == 3) write_pad(pick_pad());
      if ($urandom_range(0, 3) != 0) send_req(junk_req(OP_CLEAR));
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12))
        send_req(rand_req(OP_LOAD));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) send_req(junk_req(OP_UNUSED));
        send_req(rand_req(OP_QUERY));
      end
      seq_no++;
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 15;
    rcv_idle_pct  = 87;
    run_traffic(100);
    send_idle_pct = 87;
    rcv_idle_pct  = 15;
    run_traffic(100);
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    run_traffic(100);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    shadow_count    = 0;
    shadow_pad      = '0;
    fail_cnt        = 0;
    items_sent      = 0;
    loads_sent      = 0;
    clears_sent     = 0;
    queries_sent    = 0;
    results_checked = 0;
    misses_seen     = 0;
    cycle_cnt       = 0;
    send_idle_pct   = 15;
    rcv_idle_pct    = 87;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_cull_rules();
    test_pad_widening();
    test_clear();
    test_full_table();
    test_random_traffic();

    wait_idle();
    if (expected_hits_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_hits_q.size());
      fail_cnt++;
    end
    $display("covered %0d requests: %0d loads, %0d clears, %0d queries",
             items_sent, loads_sent, clears_sent, queries_sent);
    $display("checked %0d results, %0d of them empty queries, in %0d cycles",
             results_checked, misses_seen, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
